[design/dtfc_pkg.sv]
// Shared constants and types for the density to fire color pipeline.
// No dependencies; every other design file refers to this package by scoped names.
package dtfc_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int DENS_W     = 16;
    localparam int X_W        = DENS_W + 1;
    localparam int EXP_W      = 3;
    localparam int F_W        = EXP_W + FRAC_BITS;
    localparam int M_W        = 31;
    localparam int F2_W       = 2 * F_W - FRAC_BITS;
    localparam int F3_W       = F2_W + F_W - FRAC_BITS;
    localparam int F6_W       = 2 * F3_W - FRAC_BITS;
    localparam int PIX_W      = 32;
    localparam int LOG_DEPTH  = FRAC_BITS + 1;
    localparam int POLY_DEPTH = 4;
    localparam int PIPE_DEPTH = LOG_DEPTH + POLY_DEPTH;

    localparam logic [X_W-1:0] LOG_BIAS = X_W'(1024);
    localparam int             BIAS_MSB = 10;

    typedef struct packed {
        logic [M_W-1:0]       mant;
        logic [FRAC_BITS-1:0] frac;
        logic [EXP_W-1:0]     expo;
        logic                 alpha;
    } log_stage_t;

    typedef struct packed {
        logic [F_W-1:0] f;
        logic           alpha;
    } log_out_t;

endpackage

[design/dtfc_sq_step.sv]
// One fraction bit of the base-2 logarithm: square the mantissa, renormalize.
// Depends on dtfc_pkg.
module dtfc_sq_step (
    input  logic                  aclk,
    input  logic                  adv,
    input  dtfc_pkg::log_stage_t  stage_in,
    output dtfc_pkg::log_stage_t  stage_out
);

    logic [2*dtfc_pkg::M_W-1:0] sq;
    logic [dtfc_pkg::M_W:0]     sq_sh;
    dtfc_pkg::log_stage_t       stage_next;
    dtfc_pkg::log_stage_t       stage_reg;

    always_comb begin
        sq    = {{dtfc_pkg::M_W{1'b0}}, stage_in.mant} * {{dtfc_pkg::M_W{1'b0}}, stage_in.mant};
        sq_sh = sq[2*dtfc_pkg::M_W-1:dtfc_pkg::M_W-1];
        stage_next       = stage_in;
        stage_next.frac  = {stage_in.frac[dtfc_pkg::FRAC_BITS-2:0], sq_sh[dtfc_pkg::M_W]};
        stage_next.mant  = sq_sh[dtfc_pkg::M_W] ? sq_sh[dtfc_pkg::M_W:1]
                                                : sq_sh[dtfc_pkg::M_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

[design/dtfc_log2.sv]
// Log2 pipeline: normalize density/4 + 1, then one squaring stage per fraction bit.
// Depends on dtfc_pkg and dtfc_sq_step.
module dtfc_log2 (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [dtfc_pkg::DENS_W-1:0]   density,
    input  logic                          alpha,
    output dtfc_pkg::log_out_t            log_out
);

    dtfc_pkg::log_stage_t norm_next;
    dtfc_pkg::log_stage_t chain [dtfc_pkg::FRAC_BITS+1];

    always_comb begin
        logic [dtfc_pkg::X_W-1:0] x;
        logic [4:0]               top;
        x   = {1'b0, density} + dtfc_pkg::LOG_BIAS;
        top = 5'(dtfc_pkg::BIAS_MSB);
        for (int i = dtfc_pkg::BIAS_MSB; i < dtfc_pkg::X_W; i++) begin
            if (x[i]) begin
                top = 5'(i);
            end
        end
        norm_next.mant  = dtfc_pkg::M_W'(x) << (5'(dtfc_pkg::M_W - 1) - top);
        norm_next.frac  = '0;
        norm_next.expo  = dtfc_pkg::EXP_W'(top - 5'(dtfc_pkg::BIAS_MSB));
        norm_next.alpha = alpha;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            chain[0] <= norm_next;
        end
    end

    for (genvar g = 0; g < dtfc_pkg::FRAC_BITS; g++) begin : g_step
        dtfc_sq_step u_step (
            .aclk      (aclk),
            .adv       (adv),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    assign log_out.f     = {chain[dtfc_pkg::FRAC_BITS].expo, chain[dtfc_pkg::FRAC_BITS].frac};
    assign log_out.alpha = chain[dtfc_pkg::FRAC_BITS].alpha;

endmodule

[design/dtfc_poly.sv]
// Color stages: powers of the log value, scaling, saturation and pixel packing.
// Depends on dtfc_pkg.
module dtfc_poly (
    input  logic                         aclk,
    input  logic                         adv,
    input  dtfc_pkg::log_out_t           log_in,
    output logic [dtfc_pkg::PIX_W-1:0]   pixel
);

    localparam int RED_W   = dtfc_pkg::F_W + 2;
    localparam int GREEN_W = dtfc_pkg::F3_W + 2;

    logic [dtfc_pkg::F_W-1:0]    a_f_reg;
    logic [dtfc_pkg::F2_W-1:0]   a_f2_reg;
    logic                        a_alpha_reg;
    logic [dtfc_pkg::F3_W-1:0]   b_f3_reg;
    logic [7:0]                  b_red_reg;
    logic                        b_alpha_reg;
    logic [dtfc_pkg::F6_W-1:0]   c_f6_reg;
    logic [7:0]                  c_red_reg;
    logic [7:0]                  c_green_reg;
    logic                        c_alpha_reg;
    logic [dtfc_pkg::PIX_W-1:0]  pixel_reg;

    logic [2*dtfc_pkg::F_W-1:0]                   f2_full;
    logic [dtfc_pkg::F2_W+dtfc_pkg::F_W-1:0]      f3_full;
    logic [2*dtfc_pkg::F3_W-1:0]                  f6_full;
    logic [RED_W-1:0]                             red3;
    logic [RED_W-1:0]                             red_sh;
    logic [7:0]                                   red_next;
    logic [GREEN_W-1:0]                           green3;
    logic [GREEN_W-1:0]                           green_sh;
    logic [7:0]                                   green_next;
    logic [dtfc_pkg::F6_W-1:0]                    blue_sh;
    logic [7:0]                                   blue_next;
    logic [dtfc_pkg::PIX_W-1:0]                   pixel_next;

    always_comb begin
        f2_full = {{dtfc_pkg::F_W{1'b0}}, log_in.f} * {{dtfc_pkg::F_W{1'b0}}, log_in.f};
        f3_full = {{dtfc_pkg::F_W{1'b0}}, a_f2_reg} * {{dtfc_pkg::F2_W{1'b0}}, a_f_reg};
        f6_full = {{dtfc_pkg::F3_W{1'b0}}, b_f3_reg} * {{dtfc_pkg::F3_W{1'b0}}, b_f3_reg};

        red3     = {2'b00, a_f_reg} + {1'b0, a_f_reg, 1'b0};
        red_sh   = red3 >> (dtfc_pkg::FRAC_BITS - 7);
        red_next = (|red_sh[RED_W-1:8]) ? 8'hFF : red_sh[7:0];

        green3     = {2'b00, b_f3_reg} + {1'b0, b_f3_reg, 1'b0};
        green_sh   = green3 >> (dtfc_pkg::FRAC_BITS - 7);
        green_next = (|green_sh[GREEN_W-1:8]) ? 8'hFF : green_sh[7:0];

        blue_sh   = c_f6_reg >> (dtfc_pkg::FRAC_BITS - 8);
        blue_next = (|blue_sh[dtfc_pkg::F6_W-1:8]) ? 8'hFF : blue_sh[7:0];

        pixel_next = {{8{c_alpha_reg}}, blue_next, c_green_reg, c_red_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_f_reg     <= log_in.f;
            a_f2_reg    <= f2_full[2*dtfc_pkg::F_W-1:dtfc_pkg::FRAC_BITS];
            a_alpha_reg <= log_in.alpha;
            b_f3_reg    <= f3_full[dtfc_pkg::F2_W+dtfc_pkg::F_W-1:dtfc_pkg::FRAC_BITS];
            b_red_reg   <= red_next;
            b_alpha_reg <= a_alpha_reg;
            c_f6_reg    <= f6_full[2*dtfc_pkg::F3_W-1:dtfc_pkg::FRAC_BITS];
            c_red_reg   <= b_red_reg;
            c_green_reg <= green_next;
            c_alpha_reg <= b_alpha_reg;
            pixel_reg   <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

[design/density_to_fire_color_unit.sv]
// Top level of the density to fire color pipeline: handshake, valid tracking, threshold.
// Depends on dtfc_pkg, dtfc_log2 and dtfc_poly.
//
// Usage:
//   s_ channel: one density request per beat, tdata = density (unsigned Q8.8).
//   m_ channel: one pixel per request, tdata = {alpha, blue, green, red}.
//   cfg_wr_en / cfg_wr_data: write the alpha threshold; write only while idle.
// The color is a fire palette of f = log2(density/4 + 1) in Q3.12.
// Pipeline: an accepted request passes a normalization register, one squaring
// stage per fraction bit of the logarithm (12 squaring stages, one 31x31
// multiplier each) and four power, scale and pack stages before m_tvalid.
// Throughput: one request per cycle, sustained while the output is not stalled.
// Reset: clears all valid bits and sets the threshold to 128 (0.5).
// Stall: when m_tready is low with a pixel waiting, the whole pipeline holds
// and s_tready drops; bubbles move forward while the output slot is empty.
module density_to_fire_color_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] density
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [31:0] pixel_word
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [dtfc_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [dtfc_pkg::PIPE_DEPTH-1:0] valid_next;
    logic [dtfc_pkg::DENS_W-1:0]     thresh_reg;
    logic [dtfc_pkg::DENS_W-1:0]     thresh_next;
    logic                            adv;
    logic                            alpha_in;
    dtfc_pkg::log_out_t              log_val;
    logic [dtfc_pkg::PIX_W-1:0]      pixel;

    assign adv        = !valid_reg[dtfc_pkg::PIPE_DEPTH-1] || m_tready;
    assign s_tready   = adv;
    assign alpha_in   = s_tdata > thresh_reg;
    assign valid_next = {valid_reg[dtfc_pkg::PIPE_DEPTH-2:0], s_tvalid};
    assign thresh_next = cfg_wr_en ? cfg_wr_data : thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            thresh_reg <= dtfc_pkg::DENS_W'(128);
        end else begin
            thresh_reg <= thresh_next;
            if (adv) begin
                valid_reg <= valid_next;
            end
        end
    end

    dtfc_log2 u_log2 (
        .aclk    (aclk),
        .adv     (adv),
        .density (s_tdata),
        .alpha   (alpha_in),
        .log_out (log_val)
    );

    dtfc_poly u_poly (
        .aclk   (aclk),
        .adv    (adv),
        .log_in (log_val),
        .pixel  (pixel)
    );

    assign m_tvalid = valid_reg[dtfc_pkg::PIPE_DEPTH-1];
    assign m_tdata  = pixel;

endmodule

[sim/tb_top.sv]
// Self-checking bench for density_to_fire_color_unit: streams densities, predicts each
// fire-palette pixel in a bit-true log2/power model and compares every returned pixel.
// Depends on dtfc_pkg and the density_to_fire_color_unit RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC_BITS   = dtfc_pkg::FRAC_BITS;
    localparam int DRAIN_WAIT  = dtfc_pkg::PIPE_DEPTH + 4;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 500;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    logic [15:0] pending_density [$];
    logic [31:0] expected_pixels [$];
    logic [15:0] threshold_shadow = 16'd128;
    logic        req_taken = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_done = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          pixel_count = 0;
    int          idle_cycles = 0;
    int          fail_count = 0;

    logic [15:0] corner_density [22] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd127, 16'd128, 16'd129, 16'd255,
        16'd256, 16'd1023, 16'd1024, 16'd3071, 16'd3072, 16'd4096, 16'd16383, 16'd16384,
        16'd32767, 16'd32768, 16'h5555, 16'hAAAA, 16'd65534, 16'd65535
    };

    density_to_fire_color_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [7:0] clip_byte(input logic [63:0] v);
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [31:0] fire_pixel(input logic [15:0] dens, input logic [15:0] thr);
        logic [16:0] x;
        logic [63:0] m;
        logic [63:0] f;
        logic [63:0] f2;
        logic [63:0] f3;
        logic [63:0] f6;
        logic [FRAC_BITS-1:0] frac;
        logic [7:0] alpha;
        int top;
        int i;
        x = {1'b0, dens} + 17'd1024;
        top = 0;
        for (i = 0; i < 17; i++)
            if (x[i]) top = i;
        m = 64'(x) << (30 - top);
        frac = '0;
        for (i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> 30;
            frac = {frac[FRAC_BITS-2:0], m[31]};
            if (m[31]) m = m >> 1;
        end
        f  = (64'(top - 10) << FRAC_BITS) | 64'(frac);
        f2 = (f * f) >> FRAC_BITS;
        f3 = (f2 * f) >> FRAC_BITS;
        f6 = (f3 * f3) >> FRAC_BITS;
        alpha = (dens > thr) ? 8'd255 : 8'd0;
        return {alpha, clip_byte(f6 >> (FRAC_BITS - 8)), clip_byte((3 * f3) >> (FRAC_BITS - 7)),
                clip_byte((3 * f) >> (FRAC_BITS - 7))};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] random_density();
        int r;
        int k;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            4, 5: v = $urandom_range(0, 1023);
            6: begin
                k = $urandom_range(11, 16);
                v = (1 << k) - 1024 + $urandom_range(0, 4) - 2;
            end
            7: v = threshold_shadow + $urandom_range(0, 4) - 2;
            8: v = $urandom_range(0, 1) ? 65535 : 0;
            9: v = 1 << $urandom_range(0, 15);
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // request driver
    always @(negedge aclk) begin
        logic       nxt_valid;
        logic [15:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_tvalid && req_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_density.size() != 0) begin
                    nxt_data  = pending_density.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = no_idle ? 0 : pick_gap();
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // pixel receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && pixel_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_pixels.push_back(fire_pixel(s_tdata, threshold_shadow));
            if (m_tvalid && m_tready) begin
                pixel_count++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel %08h with no pending request", m_tdata));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("pixel %08h, expected %08h", m_tdata, want));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("** density_to_fire_color_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_density.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en        <= 1'b1;
        cfg_wr_data      <= value;
        threshold_shadow = value;
        @(negedge aclk);
        cfg_wr_en        <= 1'b0;
    endtask

    task automatic queue_requests(input bit corners, input int n_random);
        int i;
        if (corners)
            foreach (corner_density[j]) pending_density.push_back(corner_density[j]);
        for (i = 0; i < n_random; i++)
            pending_density.push_back(random_density());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_requests(1'b1, 300);

        write_threshold(16'd0);
        no_idle = 1'b1;
        queue_requests(1'b1, 300);

        wait_idle();
        no_idle = 1'b0;
        write_threshold(16'd65535);
        queue_requests(1'b1, 300);

        write_threshold(16'($urandom_range(1, 65534)));
        queue_requests(1'b0, 350);

        write_threshold(16'd128);
        queue_requests(1'b0, 300);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never returned", expected_pixels.size()));
        if (fail_count == 0)
            $display("** density_to_fire_color_unit: PASSED **");
        else
            $display("** density_to_fire_color_unit: FAILED **");
        $finish;
    end

endmodule
